### design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_NOW(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### design/bhfp_pkg.sv
// ---------------------------------------------------------------------------
// bhfp_pkg
// Types, codes and the preamble table of the bitstream header parser.
// ---------------------------------------------------------------------------
package bhfp_pkg;

   localparam int PreambleLengthDef = 13;
   localparam int MaxFieldsDef      = 6;
   localparam int SizeBytesDef      = 4;

   localparam int PosWidth = 19;

   localparam logic [7:0] WantedFieldReset = 8'd101;
   localparam logic [7:0] DataFieldIdReset = 8'd101;

   // configuration register indexes
   localparam logic CSR_WANTED_FIELD  = 1'b0;
   localparam logic CSR_DATA_FIELD_ID = 1'b1;

   // result status codes
   localparam logic [1:0] ST_FOUND     = 2'd0;
   localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   // parser phases
   localparam logic [2:0] PH_PREAMBLE = 3'd0;
   localparam logic [2:0] PH_ID       = 3'd1;
   localparam logic [2:0] PH_LEN_HI   = 3'd2;
   localparam logic [2:0] PH_LEN_LO   = 3'd3;
   localparam logic [2:0] PH_SKIP     = 3'd4;
   localparam logic [2:0] PH_WANT_LEN = 3'd5;
   localparam logic [2:0] PH_SIZE     = 3'd6;
   localparam logic [2:0] PH_DONE     = 3'd7;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       start_of_file;
   } req_word_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [PosWidth-1:0] content_offset;
      logic [31:0]         stream_size;
   } rsp_word_type;

   // fixed file preamble; positions past the thirteenth read as zero
   function automatic logic [7:0] magic_byte(input logic [3:0] idx);
      logic [7:0] b;
      case (idx)
         4'd1:                          b = 8'h09;
         4'd2, 4'd4, 4'd6, 4'd8:        b = 8'h0f;
         4'd3, 4'd5, 4'd7, 4'd9:        b = 8'hf0;
         4'd12:                         b = 8'h01;
         default:                       b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

### design/bitstream_header_field_parser.sv
// ---------------------------------------------------------------------------
// bitstream_header_field_parser
// Streams a bitstream file byte by byte, checks the preamble and locates a
// wanted header field; reports its content offset and, for the data field,
// the bitstream size.
// ---------------------------------------------------------------------------
//
//   channel | direction | handshake             | word
//   --------+-----------+-----------------------+------------------------------
//   req_    | in        | req_valid / req_ready | file_byte, start_of_file
//   rsp_    | out       | rsp_valid / rsp_ready | status, content_offset, size
//   csr_    | in        | csr_we                | csr_index, csr_wdata
//
// One byte per cycle sustained while no result is held. A byte is registered
// in the input register and is parsed on the way into the result register.
// The parse state is updated together with the result register, which is what
// lets the next byte follow at once. Reset is synchronous and clears the parse
// state, the configuration and the valid flags to their defaults; the input
// word and the result word are not reset. A held result stalls the parser; the
// input register still takes one more word before req_ready drops.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bitstream_header_field_parser
   import bhfp_pkg::*;
#(
   parameter int PREAMBLE_LENGTH = PreambleLengthDef,
   parameter int MAX_FIELDS      = MaxFieldsDef,
   parameter int SIZE_BYTES      = SizeBytesDef
) (
   input  logic         clock,
   input  logic         reset,

   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,

   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data,

   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [7:0]   csr_wdata
);

   // thresholds sized to the counters they are compared with
   localparam logic [4:0] PreambleLenW = 5'(PREAMBLE_LENGTH);
   localparam logic [2:0] MaxFieldsW   = 3'(MAX_FIELDS);
   localparam logic [2:0] SizeBytesW   = 3'(SIZE_BYTES);

   // configuration
   logic [7:0] wanted_field_ff;
   logic [7:0] data_field_id_ff;

   // input register
   logic         in_valid_ff;
   req_word_type in_word_ff;

   // parse state
   logic [2:0]          phase_ff,      phase_in;
   logic [3:0]          pre_idx_ff,    pre_idx_in;
   logic [2:0]          fields_ff,     fields_in;
   logic [15:0]         skip_ff,       skip_in;
   logic [PosWidth-1:0] pos_ff,        pos_in;
   logic [31:0]         size_acc_ff,   size_acc_in;
   logic [2:0]          size_cnt_ff,   size_cnt_in;

   // result register
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff, rsp_word_in;
   logic         emit;

   logic advance;   // result register can take a new value
   logic step;      // a byte is parsed this cycle

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

   // ------------------------------------------------------------------
   // Parser: one byte in, state and optional result out.
   // ------------------------------------------------------------------
   always_comb begin
      logic [2:0]          cur_phase;
      logic [3:0]          cur_idx;
      logic [2:0]          cur_fields;
      logic [15:0]         cur_skip;
      logic [PosWidth-1:0] cur_pos;
      logic [31:0]         cur_acc;
      logic [2:0]          cur_cnt;
      logic [7:0]          b;
      logic [3:0]          idx_inc;
      logic [15:0]         skip_dec;
      logic [15:0]         len_full;
      logic [PosWidth-1:0] pos_inc;

      b = in_word_ff.file_byte;

      // a start flag restarts the file on this very byte
      if (in_word_ff.start_of_file) begin
         cur_phase  = PH_PREAMBLE;
         cur_idx    = '0;
         cur_fields = '0;
         cur_skip   = '0;
         cur_pos    = '0;
         cur_acc    = '0;
         cur_cnt    = '0;
      end else begin
         cur_phase  = phase_ff;
         cur_idx    = pre_idx_ff;
         cur_fields = fields_ff;
         cur_skip   = skip_ff;
         cur_pos    = pos_ff;
         cur_acc    = size_acc_ff;
         cur_cnt    = size_cnt_ff;
      end

      idx_inc  = cur_idx + 4'd1;
      skip_dec = cur_skip - 16'd1;
      len_full = cur_skip | {8'h00, b};
      pos_inc  = cur_pos + PosWidth'(1);

      phase_in    = cur_phase;
      pre_idx_in  = cur_idx;
      fields_in   = cur_fields;
      skip_in     = cur_skip;
      pos_in      = pos_inc;
      size_acc_in = cur_acc;
      size_cnt_in = cur_cnt;

      emit        = 1'b0;
      rsp_word_in = '{status: ST_FOUND, content_offset: '0, stream_size: '0};

      unique case (cur_phase)
         PH_PREAMBLE: begin
            if (b != magic_byte(cur_idx)) begin
               emit                 = 1'b1;
               rsp_word_in.status   = ST_BAD_MAGIC;
            end else begin
               pre_idx_in = idx_inc;
               if ({1'b0, idx_inc} >= PreambleLenW || idx_inc == 4'd0) begin
                  phase_in = PH_ID;
               end
            end
         end
         PH_ID: begin
            if (b == wanted_field_ff) begin
               if (wanted_field_ff == data_field_id_ff) begin
                  size_acc_in = '0;
                  size_cnt_in = '0;
                  phase_in    = PH_SIZE;
               end else begin
                  skip_in  = 16'd1;   // two length bytes to pass over
                  phase_in = PH_WANT_LEN;
               end
            end else begin
               fields_in = cur_fields + 3'd1;
               phase_in  = PH_LEN_HI;
            end
         end
         PH_LEN_HI: begin
            skip_in  = {b, 8'h00};
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            skip_in = len_full;
            if (len_full == 16'd0) begin
               if (cur_fields >= MaxFieldsW) begin
                  emit               = 1'b1;
                  rsp_word_in.status = ST_NOT_FOUND;
               end else begin
                  phase_in = PH_ID;
               end
            end else begin
               phase_in = PH_SKIP;
            end
         end
         PH_SKIP: begin
            skip_in = skip_dec;
            if (skip_dec == 16'd0) begin
               if (cur_fields >= MaxFieldsW) begin
                  emit               = 1'b1;
                  rsp_word_in.status = ST_NOT_FOUND;
               end else begin
                  phase_in = PH_ID;
               end
            end
         end
         PH_WANT_LEN: begin
            if (cur_skip == 16'd0) begin
               emit                       = 1'b1;
               rsp_word_in.content_offset = pos_inc;
            end else begin
               skip_in = skip_dec;
            end
         end
         PH_SIZE: begin
            size_acc_in = {cur_acc[23:0], b};
            size_cnt_in = cur_cnt + 3'd1;
            if (size_cnt_in >= SizeBytesW) begin
               emit                       = 1'b1;
               rsp_word_in.content_offset = pos_inc;
               rsp_word_in.stream_size    = size_acc_in;
            end
         end
         PH_DONE: begin
            // idle until the next start flag
         end
         default: begin
         end
      endcase

      if (emit) begin
         phase_in = PH_DONE;
      end
   end

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_field_ff  <= WantedFieldReset;
         data_field_id_ff <= DataFieldIdReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WANTED_FIELD:  wanted_field_ff  <= csr_wdata;
            CSR_DATA_FIELD_ID: data_field_id_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_word_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_PREAMBLE;
         pre_idx_ff  <= '0;
         fields_ff   <= '0;
         skip_ff     <= '0;
         pos_ff      <= '0;
         size_acc_ff <= '0;
         size_cnt_ff <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         pre_idx_ff  <= pre_idx_in;
         fields_ff   <= fields_in;
         skip_ff     <= skip_in;
         pos_ff      <= pos_in;
         size_acc_ff <= size_acc_in;
         size_cnt_ff <= size_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `ASSERT_NOW(a_fail_word_zero, clock, reset,
      rsp_valid && rsp_data.status != ST_FOUND,
      rsp_data.content_offset == '0 && rsp_data.stream_size == '0)
   `ASSERT_NEXT(a_emit_goes_done, clock, reset, step && emit, phase_ff == PH_DONE)
   `ASSERT_NOW(a_stall_only_when_held, clock, reset,
      !req_ready, in_valid_ff && rsp_valid && !rsp_ready)

endmodule
